// File: design/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: design/hucm_pkg.sv
// Package: shared types, constants and helpers of the Huffman table-match decoder
`timescale 1ns / 1ps
package hucm_pkg;
    localparam int MAX_CODE_LEN  = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int BIT_W   = $clog2(BYTE_W);

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DUP     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BITS,
        ST_FLUSH
    } t_state;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
    } t_entry;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_key;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] sym;
    } t_match;

    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] code,
                                                    input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return code & m;
    endfunction
endpackage

// File: design/hucm_cell.sv
// One table cell: holds an entry, shifts it on to the next cell on load, compares it to the key
`timescale 1ns / 1ps
module hucm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  hucm_pkg::t_entry i_prev,
    input  hucm_pkg::t_key   i_key,
    output hucm_pkg::t_entry o_entry,
    output hucm_pkg::t_match o_match
);
    import hucm_pkg::*;

    logic              r_valid;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_code;
    logic [SYM_W-1:0]  r_sym;
    logic              w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_len  <= i_prev.len;
            r_code <= i_prev.code;
            r_sym  <= i_prev.sym;
        end
    end

    assign w_hit       = r_valid && (r_len == i_key.len) && (r_code == i_key.code);
    assign o_entry     = {r_valid, r_len, r_code, r_sym};
    assign o_match.hit = w_hit;
    assign o_match.sym = w_hit ? r_sym : '0;
endmodule

// File: design/hucm_chain.sv
// Row of table cells; new entries enter at the head, unique matches are OR-combined
`timescale 1ns / 1ps
module hucm_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  hucm_pkg::t_entry i_new,
    input  hucm_pkg::t_key   i_key,
    output hucm_pkg::t_match o_match
);
    import hucm_pkg::*;

    t_entry w_link [TABLE_ENTRIES+1];
    t_match w_m    [TABLE_ENTRIES];

    assign w_link[0] = i_new;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        hucm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_prev  (w_link[g]),
            .i_key   (i_key),
            .o_entry (w_link[g+1]),
            .o_match (w_m[g])
        );
    end

    // duplicates are refused on load, so at most one cell can hit
    always_comb begin
        o_match = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            o_match.hit = o_match.hit | w_m[i].hit;
            o_match.sym = o_match.sym | w_m[i].sym;
        end
    end
endmodule

// File: design/huffman_table_match_decoder_top.sv
// Sequence: a load word passes through ST_LOAD to the result register; a decode word walks
// its byte in ST_BITS, then ST_FLUSH sends the final pending result. One input word at a time;
// the bit walk runs one bit per cycle against the cell row, and output stalls pause it.
// Reset: synchronous active-low clears table valid bits, entry count and accumulator.
// Results: a load gives one word; a decode gives 0 to 8, the final one marked last.
`timescale 1ns / 1ps
module huffman_table_match_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [hucm_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hucm_pkg::LEN_W-1:0]  i_code_length,
    input  logic [hucm_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hucm_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_has_symbol,
    output logic [hucm_pkg::SYM_W-1:0]  o_out_symbol,
    output logic [1:0]                  o_status,
    output logic                        o_last
);
    import hucm_pkg::*;

    t_state r_state, n_state;
    logic [SYM_W-1:0]  r_sym;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_code;
    logic [BYTE_W-1:0] r_byte;
    logic [BIT_W-1:0]  r_bit;
    logic [CNT_W-1:0]  r_count;
    logic [CODE_W-1:0] r_acc;
    logic [ACC_W-1:0]  r_acc_len;

    logic              r_pend_v;
    logic              r_pend_has;
    logic [SYM_W-1:0]  r_pend_sym;
    t_status           r_pend_st;

    logic              r_out_v;
    logic              r_out_has;
    logic [SYM_W-1:0]  r_out_sym;
    t_status           r_out_st;
    logic              r_out_last;

    logic              w_accept, w_out_free, w_out_set;
    logic [CODE_W-1:0] w_acc_n;
    logic [ACC_W-1:0]  w_acc_len_n;
    t_key              w_key;
    t_entry            w_new;
    t_match            w_match;
    logic              w_full, w_store, w_step, w_res, w_res_has;
    t_status           w_res_st;

    assign w_accept    = i_valid && o_ready;
    assign w_out_free  = !r_out_v || i_ready;
    assign w_acc_n     = {r_acc[CODE_W-2:0], r_byte[BYTE_W-1]};
    assign w_acc_len_n = r_acc_len + ACC_W'(1);
    assign w_full      = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_out_set   = (w_res && r_pend_v)
                         || (w_out_free && ((r_state == ST_LOAD)
                                            || ((r_state == ST_FLUSH) && r_pend_v)));

    always_comb begin
        if (r_state == ST_LOAD) begin
            w_key.len  = r_len;
            w_key.code = r_code;
        end else begin
            w_key.len  = LEN_W'(w_acc_len_n);
            w_key.code = w_acc_n;
        end
    end

    assign w_new.valid = 1'b1;
    assign w_new.len   = r_len;
    assign w_new.code  = r_code;
    assign w_new.sym   = r_sym;

    hucm_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_store),
        .i_new   (w_new),
        .i_key   (w_key),
        .o_match (w_match)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_command == CMD_LOAD) ? ST_LOAD : ST_BITS;
                end
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BITS: begin
                if (w_out_free && (r_bit == BIT_W'(BYTE_W - 1))) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready   = 1'b0;
        w_store   = 1'b0;
        w_step    = 1'b0;
        w_res     = 1'b0;
        w_res_has = 1'b0;
        w_res_st  = STAT_OK;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_LOAD: w_store = w_out_free && !w_match.hit && !w_full;
            ST_BITS: begin
                w_step = w_out_free;
                if (w_match.hit) begin
                    w_res     = w_out_free;
                    w_res_has = 1'b1;
                end else if (w_acc_len_n >= ACC_W'(MAX_CODE_LEN)) begin
                    w_res    = w_out_free;
                    w_res_st = STAT_NOMATCH;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_acc     <= '0;
            r_acc_len <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_bit     <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_set) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_accept) begin
                r_bit <= '0;
            end else if (w_step) begin
                r_bit <= r_bit + BIT_W'(1);
            end
            if (w_step) begin
                if (w_res) begin
                    r_acc     <= '0;
                    r_acc_len <= '0;
                    r_pend_v  <= 1'b1;
                end else begin
                    r_acc     <= w_acc_n;
                    r_acc_len <= w_acc_len_n;
                end
            end
            if ((r_state == ST_FLUSH) && w_out_free) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym  <= i_symbol;
            r_len  <= i_code_length;
            r_code <= mask_code(i_code_bits, i_code_length);
            r_byte <= i_data_byte;
        end else if (w_step) begin
            r_byte <= {r_byte[BYTE_W-2:0], 1'b0};
        end
        if (w_res) begin
            r_pend_has <= w_res_has;
            r_pend_sym <= w_match.sym;
            r_pend_st  <= w_res_st;
        end
        if ((r_state == ST_LOAD) && w_out_free) begin
            r_out_has  <= 1'b0;
            r_out_sym  <= '0;
            r_out_st   <= w_match.hit ? STAT_DUP : (w_full ? STAT_FULL : STAT_OK);
            r_out_last <= 1'b1;
        end else if (w_res && r_pend_v) begin
            r_out_has  <= r_pend_has;
            r_out_sym  <= r_pend_sym;
            r_out_st   <= r_pend_st;
            r_out_last <= 1'b0;
        end else if ((r_state == ST_FLUSH) && w_out_free) begin
            r_out_has  <= r_pend_has;
            r_out_sym  <= r_pend_sym;
            r_out_st   <= r_pend_st;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid      = r_out_v;
    assign o_has_symbol = r_out_has;
    assign o_out_symbol = r_out_sym;
    assign o_status     = r_out_st;
    assign o_last       = r_out_last;
endmodule

// File: design/hucm_checker.sv
// Port-level checker for the Huffman table-match decoder, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hucm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_has_symbol,
    input logic [7:0] o_out_symbol,
    input logic [1:0] o_status,
    input logic       o_last
);
    import hucm_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_out_symbol))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ASSERT_SAME(a_sym_ok, i_clk, i_rst_n, o_valid && o_has_symbol, o_status == STAT_OK)
    `ASSERT_SAME(a_load_last, i_clk, i_rst_n, o_valid && (o_status == STAT_DUP || o_status == STAT_FULL), o_last && !o_has_symbol)
endmodule

bind huffman_table_match_decoder_top hucm_checker u_hucm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_has_symbol (o_has_symbol),
    .o_out_symbol (o_out_symbol),
    .o_status     (o_status),
    .o_last       (o_last)
);

// File: tb/testbench.sv
// Testbench for the Huffman table-match decoder: table loads and byte decodes checked against a predictor
`timescale 1ns / 1ps

class huff_scoreboard;
    typedef struct {
        logic       has;
        logic [7:0] sym;
        logic [1:0] stat;
        logic       last;
    } t_word;

    logic        tab_valid [256];
    logic [4:0]  tab_len [256];
    logic [15:0] tab_code [256];
    logic [7:0]  tab_sym [256];
    int          tab_count;
    logic [15:0] acc_bits;
    int          acc_len;
    t_word       pending [$];
    int          errors;

    function new();
        tab_count = 0;
        acc_bits = 0;
        acc_len = 0;
        errors = 0;
        foreach (tab_valid[i]) tab_valid[i] = 1'b0;
    endfunction

    function void push(logic h, logic [7:0] s, logic [1:0] st, logic l);
        t_word w;
        w.has = h;
        w.sym = s;
        w.stat = st;
        w.last = l;
        pending.insert(pending.size(), w);
    endfunction

    function void note_input(logic cmd, logic [7:0] sym, logic [4:0] len,
                             logic [15:0] code, logic [7:0] data);
        logic [15:0] m;
        int n;
        int hit;
        n = pending.size();
        if (cmd == hucm_pkg::CMD_LOAD) begin
            for (int i = 0; i < 16; i++) m[i] = (i < len);
            code = code & m;
            for (int i = 0; i < tab_count; i++) begin
                if (tab_valid[i] && tab_len[i] == len && tab_code[i] == code) begin
                    push(0, 0, hucm_pkg::STAT_DUP, 1);
                    return;
                end
            end
            if (tab_count >= 256) begin
                push(0, 0, hucm_pkg::STAT_FULL, 1);
                return;
            end
            tab_valid[tab_count] = 1'b1;
            tab_len[tab_count] = len;
            tab_code[tab_count] = code;
            tab_sym[tab_count] = sym;
            tab_count++;
            push(0, 0, hucm_pkg::STAT_OK, 1);
            return;
        end
        for (int b = 7; b >= 0; b--) begin
            acc_bits = {acc_bits[14:0], data[b]};
            acc_len++;
            hit = -1;
            for (int i = 0; i < tab_count; i++) begin
                if (tab_valid[i] && tab_len[i] == acc_len && tab_code[i] == acc_bits) begin
                    hit = i;
                    break;
                end
            end
            if (hit >= 0) begin
                push(1, tab_sym[hit], hucm_pkg::STAT_OK, 0);
                acc_bits = 0;
                acc_len = 0;
            end else if (acc_len >= hucm_pkg::MAX_CODE_LEN) begin
                push(0, 0, hucm_pkg::STAT_NOMATCH, 0);
                acc_bits = 0;
                acc_len = 0;
            end
        end
        if (pending.size() > n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic h, logic [7:0] s, logic [1:0] st, logic l);
        t_word w;
        if (pending.size() == 0) begin
            $error("unexpected result word has=%0d sym=%0h status=%0d", h, s, st);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (h !== w.has) begin
            $error("has_symbol expected %0d got %0d", w.has, h);
            errors++;
        end
        if (s !== w.sym) begin
            $error("out_symbol expected %0h got %0h", w.sym, s);
            errors++;
        end
        if (st !== w.stat) begin
            $error("status expected %0d got %0d", w.stat, st);
            errors++;
        end
        if (l !== w.last) begin
            $error("last expected %0d got %0d", w.last, l);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [7:0]  i_symbol;
    logic [4:0]  i_code_length;
    logic [15:0] i_code_bits;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_has_symbol;
    logic [7:0]  o_out_symbol;
    logic [1:0]  o_status;
    logic        o_last;

    huff_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int cycles;
    logic [15:0] known_code [$];
    logic [4:0]  known_len [$];

    huffman_table_match_decoder_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // valid is left high after an accept; an idle gap or drain() drops it
    task automatic send_word(logic cmd, logic [7:0] sym, logic [4:0] len,
                             logic [15:0] code, logic [7:0] data);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_symbol <= sym;
        i_code_length <= len;
        i_code_bits <= code;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(cmd, sym, len, code, data);
    endtask

    task automatic load_code(logic [7:0] sym, logic [4:0] len, logic [15:0] code);
        known_code.insert(known_code.size(), code);
        known_len.insert(known_len.size(), len);
        send_word(hucm_pkg::CMD_LOAD, sym, len, code, 8'($urandom));
    endtask

    // stream built from stored codes, packed MSB first into bytes
    task automatic send_stream(int ncodes);
        logic [7:0] cur;
        int nb;
        int k;
        cur = 0;
        nb = 0;
        for (int c = 0; c < ncodes; c++) begin
            k = $urandom_range(known_code.size() - 1, 0);
            for (int b = int'(known_len[k]) - 1; b >= 0; b--) begin
                cur = {cur[6:0], (b < 16) ? known_code[k][b] : 1'b0};
                nb++;
                if (nb == 8) begin
                    send_word(hucm_pkg::CMD_DECODE, 8'($urandom), 5'($urandom),
                              16'($urandom), cur);
                    nb = 0;
                end
            end
        end
        if (nb > 0)
            send_word(hucm_pkg::CMD_DECODE, 8'($urandom), 5'($urandom), 16'($urandom),
                      cur << (8 - nb));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_has_symbol, o_out_symbol, o_status, o_last);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_command = hucm_pkg::CMD_LOAD;
        i_symbol = 0;
        i_code_length = 0;
        i_code_bits = 0;
        i_data_byte = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: no match after 16 bits
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'hFF);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'h00);
        // directed loads: extremes, upper bits ignored, duplicates, zero and excess length
        load_code(8'h00, 5'd1, 16'hFFFE);
        load_code(8'hFF, 5'd2, 16'h0002);
        load_code(8'hA5, 5'd16, 16'hFFFF);
        load_code(8'h5A, 5'd3, 16'h0006);
        send_word(hucm_pkg::CMD_LOAD, 8'h11, 5'd1, 16'h0000, 0);
        send_word(hucm_pkg::CMD_LOAD, 8'h12, 5'd16, 16'hFFFF, 0);
        send_word(hucm_pkg::CMD_LOAD, 8'hFF, 5'd0, 16'h1234, 0);
        send_word(hucm_pkg::CMD_LOAD, 8'h77, 5'd31, 16'hFFFF, 0);
        send_word(hucm_pkg::CMD_LOAD, 8'h78, 5'd17, 16'h0000, 0);
        load_code(8'hFF, 5'd4, 16'h000E);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'h00);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'hB6);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'hFF);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'hFF);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'hE5);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 81) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 81) : 0;
            if (ph == 0) hold_off <= 300;
            for (int r = 0; r < 10; r++) begin
                if ($urandom_range(3, 0) == 0)
                    send_word(1'($urandom), 8'($urandom), 5'($urandom), 16'($urandom),
                              8'($urandom));
                else if ($urandom_range(2, 0) == 0)
                    load_code(8'($urandom), 5'($urandom_range(16, 1)), 16'($urandom));
                else
                    send_stream($urandom_range(10, 1));
            end
            drain();
        end

        // fill the table to see full rejections
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sb.tab_count < 256)
            send_word(hucm_pkg::CMD_LOAD, 8'($urandom), 5'd16, 16'($urandom), 0);
        send_word(hucm_pkg::CMD_LOAD, 8'h33, 5'd16, 16'h1357, 0);
        send_word(hucm_pkg::CMD_LOAD, 8'h34, 5'd16, 16'h1357, 0);
        send_stream(6);
        send_word(hucm_pkg::CMD_DECODE, 0, 0, 0, 8'($urandom));
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
